### hdl/mecanum_wheel_speed_solver_unit_macros.svh
// Assertion macros for the mecanum wheel speed solver.
// Expects clk_i and rst_ni in the scope of use.
`ifndef MECANUM_WHEEL_SPEED_SOLVER_UNIT_MACROS_SVH
`define MECANUM_WHEEL_SPEED_SOLVER_UNIT_MACROS_SVH

// clocked check, held off during reset
`define MWSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that stays active during reset as well
`define MWSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/mwss_pkg.sv
// Shared types, constants and helpers for the mecanum wheel speed solver.
// No dependencies.
package mwss_pkg;

  localparam int unsigned NumWheels = 4;
  localparam int unsigned DivBits   = 15;
  localparam int unsigned MagW      = 17;
  localparam int unsigned InW       = 17;
  localparam int unsigned RpmW      = 16;
  localparam int unsigned SumW      = 51;
  localparam int unsigned LeverW    = 50;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLimitX      = 3'd0,
    CfgLimitY      = 3'd1,
    CfgLimitTurn   = 3'd2,
    CfgFrontGain   = 3'd3,
    CfgBackGain    = 3'd4,
    CfgRpmGain     = 3'd5,
    CfgWheelLimit  = 3'd6
  } cfg_idx_e;

  function automatic logic signed [InW-1:0] clamp_mag(input logic signed [InW-1:0] v,
                                                      input logic [15:0] lim);
    logic signed [InW-1:0] l;
    l = $signed({1'b0, lim});
    if (v > l) return l;
    else if (v < -l) return -l;
    else return v;
  endfunction

  function automatic logic [MagW-1:0] abs_rpm(input logic signed [RpmW-1:0] v);
    logic signed [MagW-1:0] e;
    e = MagW'(v);
    return v[RpmW-1] ? MagW'(-e) : MagW'(e);
  endfunction

endpackage

### hdl/mwss_cmd_if.sv
// Command channel: chassis velocity beat, valid/ready.
// Depends on mwss_pkg.
interface mwss_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mwss_pkg::InW-1:0]       speed_x;
  logic signed [mwss_pkg::InW-1:0]       speed_y;
  logic signed [mwss_pkg::InW-1:0]       turn_rate;

  modport source (output valid, speed_x, speed_y, turn_rate, input ready);
  modport sink   (input valid, speed_x, speed_y, turn_rate, output ready);
endinterface

### hdl/mwss_rpm_if.sv
// Result channel: four wheel rpm values and scale flag, valid/ready.
// Depends on mwss_pkg.
interface mwss_rpm_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mwss_pkg::RpmW-1:0]      front_left_rpm;
  logic signed [mwss_pkg::RpmW-1:0]      back_left_rpm;
  logic signed [mwss_pkg::RpmW-1:0]      back_right_rpm;
  logic signed [mwss_pkg::RpmW-1:0]      front_right_rpm;
  logic                                  was_scaled;

  modport source (output valid, front_left_rpm, back_left_rpm, back_right_rpm,
                  front_right_rpm, was_scaled, input ready);
  modport sink   (input valid, front_left_rpm, back_left_rpm, back_right_rpm,
                  front_right_rpm, was_scaled, output ready);
endinterface

### hdl/mecanum_wheel_speed_solver_unit.sv
// Mecanum wheel speed solver top level: clamp, lever products, wheel sums,
// rpm gain, saturation, max search and a pipelined proportional divider.
// Depends on mwss_pkg, mwss_cmd_if, mwss_rpm_if and the macros header.
//
// Usage:
//   cmd_i carries one velocity command per beat (speed_x, speed_y,
//   turn_rate); rpm_o returns one beat of four wheel rpm values plus
//   was_scaled for every command, in order.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i,
//   one per cycle; the user must write them only while no command is
//   in flight, as the block does not enforce it. Pipeline: 8 arithmetic
//   stages, 15 divider stages of one quotient bit each, output register.
//   One command per cycle unless rpm_o stalls; divider fully pipelined.
//   Reset: pipeline valids clear, registers take their default values.
//   Stall: when rpm_o is held off with a result waiting, the whole pipeline
//   freezes, bubbles included, and cmd_i.ready falls until the result
//   beat is taken; nothing is lost or repeated.
`include "mecanum_wheel_speed_solver_unit_macros.svh"

module mecanum_wheel_speed_solver_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mwss_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mwss_pkg::CfgDataW-1:0]     cfg_data_i,
  mwss_cmd_if.sink                          cmd_i,
  mwss_rpm_if.source                        rpm_o
);

  localparam int unsigned NW   = mwss_pkg::NumWheels;
  localparam int unsigned DB   = mwss_pkg::DivBits;
  localparam int unsigned MW   = mwss_pkg::MagW;
  localparam int unsigned IW   = mwss_pkg::InW;
  localparam int unsigned SW   = mwss_pkg::SumW;
  localparam int unsigned LW   = mwss_pkg::LeverW;
  localparam int unsigned RW   = mwss_pkg::RpmW;
  localparam int unsigned NSt  = 8 + DB;

  // ---------------- configuration ----------------
  logic [15:0] lim_x_q, lim_y_q, lim_w_q;
  logic [31:0] gain_f_q, gain_b_q, gain_rpm_q;
  logic [14:0] lim_rpm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_x_q    <= 16'd3300;
      lim_y_q    <= 16'd3300;
      lim_w_q    <= 16'd300;
      gain_f_q   <= 32'd65536;
      gain_b_q   <= 32'd65536;
      gain_rpm_q <= 32'd65536;
      lim_rpm_q  <= 15'd8500;
    end else if (cfg_we_i) begin
      unique case (mwss_pkg::cfg_idx_e'(cfg_idx_i))
        mwss_pkg::CfgLimitX:     lim_x_q    <= cfg_data_i[15:0];
        mwss_pkg::CfgLimitY:     lim_y_q    <= cfg_data_i[15:0];
        mwss_pkg::CfgLimitTurn:  lim_w_q    <= cfg_data_i[15:0];
        mwss_pkg::CfgFrontGain:  gain_f_q   <= cfg_data_i;
        mwss_pkg::CfgBackGain:   gain_b_q   <= cfg_data_i;
        mwss_pkg::CfgRpmGain:    gain_rpm_q <= cfg_data_i;
        mwss_pkg::CfgWheelLimit: lim_rpm_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic           adv;
  logic [NSt-1:0] vld_q;
  logic           out_vld_q;

  assign adv         = !out_vld_q || rpm_o.ready;
  assign cmd_i.ready = adv;
  assign rpm_o.valid = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NSt-2:0], cmd_i.valid};
      out_vld_q <= vld_q[NSt-1];
    end
  end

  // ---------------- S1: clamp ----------------
  logic signed [IW-1:0] x1_q, y1_q, w1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q <= mwss_pkg::clamp_mag(cmd_i.speed_x, lim_x_q);
      y1_q <= mwss_pkg::clamp_mag(cmd_i.speed_y, lim_y_q);
      w1_q <= mwss_pkg::clamp_mag(cmd_i.turn_rate, lim_w_q);
    end
  end

  // ---------------- S2: lever products ----------------
  logic signed [IW-1:0] x2_q, y2_q;
  logic signed [LW-1:0] rf2_q, rb2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x2_q  <= x1_q;
      y2_q  <= y1_q;
      rf2_q <= w1_q * $signed({1'b0, gain_f_q});
      rb2_q <= w1_q * $signed({1'b0, gain_b_q});
    end
  end

  // ---------------- S3: wheel sums, Q16.16 ----------------
  logic signed [SW-1:0] xe, ye, rfe, rbe;
  logic signed [SW-1:0] s3_q [NW];

  assign xe  = SW'(x2_q) <<< 16;
  assign ye  = SW'(y2_q) <<< 16;
  assign rfe = SW'(rf2_q);
  assign rbe = SW'(rb2_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q[0] <= -xe - ye + rfe;
      s3_q[1] <= -xe + ye + rfe;
      s3_q[2] <=  xe + ye + rbe;
      s3_q[3] <=  xe - ye + rbe;
    end
  end

  // ---------------- S4..S8 per wheel ----------------
  logic          neg4_q [NW];
  logic [LW-1:0] mag4_q [NW];
  logic          neg5_q [NW];
  logic [LW-1:0] ph5_q  [NW];
  logic [31:0]   pl5_q  [NW];
  logic          neg6_q [NW];
  logic [MW-1:0] m6_q   [NW];
  logic          neg7_q [NW];
  logic [MW-1:0] m7_q   [NW];
  logic          neg8_q [NW];
  logic [MW-1:0] m8_q   [NW];
  logic [31:0]   nd8_q  [NW];

  for (genvar i = 0; i < NW; i++) begin : g_wheel
    logic [63:0] pl_full;
    logic [SW-1:0] qsum;
    logic [MW-1:0] msat;

    assign pl_full = mag4_q[i][31:0] * gain_rpm_q;
    assign qsum    = SW'(ph5_q[i]) + SW'(pl5_q[i]);

    always_comb begin
      if (neg5_q[i]) msat = (qsum > SW'(32768)) ? MW'(32768) : qsum[MW-1:0];
      else           msat = (qsum > SW'(32767)) ? MW'(32767) : qsum[MW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        neg4_q[i] <= s3_q[i][SW-1];
        mag4_q[i] <= s3_q[i][SW-1] ? LW'(-s3_q[i]) : LW'(s3_q[i]);
        neg5_q[i] <= neg4_q[i];
        ph5_q[i]  <= LW'(mag4_q[i][LW-1:32] * gain_rpm_q);
        pl5_q[i]  <= pl_full[63:32];
        neg6_q[i] <= neg5_q[i];
        m6_q[i]   <= msat;
        neg7_q[i] <= neg6_q[i];
        m7_q[i]   <= m6_q[i];
        neg8_q[i] <= neg7_q[i];
        m8_q[i]   <= m7_q[i];
        nd8_q[i]  <= 32'(m7_q[i] * lim_rpm_q);
      end
    end
  end

  // ---------------- S7: max magnitude, S8: scale decision ----------------
  logic [MW-1:0] mx01, mx23;
  logic [MW-1:0] max7_q, max8_q;
  logic          sc8_q;

  assign mx01 = (m6_q[0] > m6_q[1]) ? m6_q[0] : m6_q[1];
  assign mx23 = (m6_q[2] > m6_q[3]) ? m6_q[2] : m6_q[3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      max7_q <= (mx01 > mx23) ? mx01 : mx23;
      max8_q <= max7_q;
      sc8_q  <= max7_q > MW'(lim_rpm_q);
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  logic [MW-1:0] dr_q   [DB][NW];
  logic [DB-1:0] dl_q   [DB][NW];
  logic [DB-1:0] dq_q   [DB][NW];
  logic          dneg_q [DB][NW];
  logic [MW-1:0] dm_q   [DB][NW];
  logic [MW-1:0] dmax_q [DB];
  logic          dsc_q  [DB];

  for (genvar j = 0; j < DB; j++) begin : g_div
    logic [MW-1:0] dvs;
    assign dvs = (j == 0) ? max8_q : dmax_q[(j == 0) ? 0 : j-1];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dmax_q[j] <= dvs;
        dsc_q[j]  <= (j == 0) ? sc8_q : dsc_q[(j == 0) ? 0 : j-1];
      end
    end

    for (genvar i = 0; i < NW; i++) begin : g_lane
      logic [MW-1:0] r_in;
      logic [DB-1:0] l_in, q_in;
      logic [MW:0]   t;
      logic          ge;

      always_comb begin
        if (j == 0) begin
          r_in = MW'(nd8_q[i][31:DB]);
          l_in = nd8_q[i][DB-1:0];
          q_in = '0;
        end else begin
          r_in = dr_q[(j == 0) ? 0 : j-1][i];
          l_in = dl_q[(j == 0) ? 0 : j-1][i];
          q_in = dq_q[(j == 0) ? 0 : j-1][i];
        end
        t  = {r_in, l_in[DB-1]};
        ge = t >= {1'b0, dvs};
      end

      always_ff @(posedge clk_i) begin
        if (adv) begin
          dr_q[j][i]   <= ge ? MW'(t - {1'b0, dvs}) : MW'(t);
          dl_q[j][i]   <= l_in << 1;
          dq_q[j][i]   <= {q_in[DB-2:0], ge};
          dneg_q[j][i] <= (j == 0) ? neg8_q[i] : dneg_q[(j == 0) ? 0 : j-1][i];
          dm_q[j][i]   <= (j == 0) ? m8_q[i] : dm_q[(j == 0) ? 0 : j-1][i];
        end
      end
    end
  end

  // ---------------- output register ----------------
  logic signed [RW-1:0] vout [NW];
  logic                 sc_q;

  for (genvar i = 0; i < NW; i++) begin : g_out
    logic [MW-1:0] mf;
    assign mf = dsc_q[DB-1] ? MW'(dq_q[DB-1][i]) : dm_q[DB-1][i];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        vout[i] <= dneg_q[DB-1][i] ? RW'(-mf) : RW'(mf);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) sc_q <= dsc_q[DB-1];
  end

  assign rpm_o.front_left_rpm  = vout[0];
  assign rpm_o.back_left_rpm   = vout[1];
  assign rpm_o.back_right_rpm  = vout[2];
  assign rpm_o.front_right_rpm = vout[3];
  assign rpm_o.was_scaled      = sc_q;

  // ---------------- assertions ----------------
  `MWSS_ASSERT(a_out_within_limit,
    out_vld_q |-> (mwss_pkg::abs_rpm(vout[0]) <= MW'(lim_rpm_q)) &&
                  (mwss_pkg::abs_rpm(vout[1]) <= MW'(lim_rpm_q)) &&
                  (mwss_pkg::abs_rpm(vout[2]) <= MW'(lim_rpm_q)) &&
                  (mwss_pkg::abs_rpm(vout[3]) <= MW'(lim_rpm_q)),
    "wheel rpm above limit")
  `MWSS_ASSERT(a_div_nonzero,
    vld_q[7] && sc8_q |-> max8_q != '0,
    "scaling with zero divisor")
  `MWSS_ASSERT(a_rem_below_divisor,
    vld_q[NSt-1] && dsc_q[DB-1] |-> (dr_q[DB-1][0] < dmax_q[DB-1]) &&
                                   (dr_q[DB-1][3] < dmax_q[DB-1]),
    "divider remainder not reduced")
  `MWSS_ASSERT_ALWAYS(a_reset_empty,
    !rst_ni |-> !out_vld_q && vld_q == '0,
    "pipeline not empty in reset")

endmodule
